// ===== rtl/cbc_pkg.sv =====
// Shared types and constants for the cascaded balance controller.
// Holds the configuration register map, the register bundle type and the
// widths of the serial multiplier. No dependencies.
package cbc_pkg;

  localparam int FIELD_W     = 16;
  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 31;
  localparam int INTEG_W     = 32;
  localparam int DRIVE_W     = 32;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_INDEX_W = 3;

  // Register map of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_GAIN       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_GAIN       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_PROP_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_INT_GAIN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_OFFSET    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd5;

  // Reset values of the registers.
  localparam logic [GAIN_W-1:0]          RST_TILT_GAIN       = 24'd2064;
  localparam logic [GAIN_W-1:0]          RST_RATE_GAIN       = 24'd98;
  localparam logic [GAIN_W-1:0]          RST_SPEED_PROP_GAIN = 24'd85197;
  localparam logic [GAIN_W-1:0]          RST_SPEED_INT_GAIN  = 24'd229;
  localparam logic signed [FIELD_W-1:0]  RST_PITCH_OFFSET    = 16'sd0;
  localparam logic [LIMIT_W-1:0]         RST_INTEGRAL_LIMIT  = 31'd251658240;

  // Serial multiplier: signed multiplicand times unsigned gain, two gain
  // bits retired per cycle.
  localparam int MUL_DIGIT_W = 2;
  localparam int MUL_M_W     = 43;
  localparam int MUL_STEPS   = GAIN_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = 4;
  localparam int MUL_ACC_W   = MUL_M_W + 1;
  localparam int MUL_SUM_W   = MUL_ACC_W + MUL_DIGIT_W;
  localparam int MUL_P_W     = MUL_M_W + GAIN_W;

  // Datapath widths of the control law.
  localparam int ERR_W   = 18;   // speed error, Q.9
  localparam int PDIFF_W = 17;   // pitch minus offset, Q8.8
  localparam int SUM_W   = 42;   // integral sum and target pitch, Q.24
  localparam int ACCUM_W = 52;   // drive before saturation, Q.24

  typedef struct packed {
    logic [GAIN_W-1:0]         tilt_gain;
    logic [GAIN_W-1:0]         rate_gain;
    logic [GAIN_W-1:0]         speed_prop_gain;
    logic [GAIN_W-1:0]         speed_int_gain;
    logic signed [FIELD_W-1:0] pitch_offset;
    logic [LIMIT_W-1:0]        integral_limit;
  } cfg_t;

endpackage

// ===== rtl/cbc_in_if.sv =====
// Input channel of the balance controller: one control tick per beat.
// Depends on cbc_pkg for the field width.
interface cbc_in_if;
  import cbc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pitch_angle;
  logic signed [FIELD_W-1:0] pitch_rate;
  logic signed [FIELD_W-1:0] wheel_speed_right;
  logic signed [FIELD_W-1:0] wheel_speed_left;
  logic signed [FIELD_W-1:0] speed_command;

  modport source (
    output valid, pitch_angle, pitch_rate, wheel_speed_right, wheel_speed_left,
           speed_command,
    input  ready
  );

  modport sink (
    input  valid, pitch_angle, pitch_rate, wheel_speed_right, wheel_speed_left,
           speed_command,
    output ready
  );
endinterface

// ===== rtl/cbc_out_if.sv =====
// Output channel of the balance controller: one drive result per beat.
// Depends on cbc_pkg for the drive width.
interface cbc_out_if;
  import cbc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] motor_drive;
  logic                      integral_clamped;

  modport source (
    output valid, motor_drive, integral_clamped,
    input  ready
  );

  modport sink (
    input  valid, motor_drive, integral_clamped,
    output ready
  );
endinterface

// ===== rtl/cascaded_balance_controller_core.sv =====
// Cascaded balance controller: outer PI speed loop, inner PD pitch loop.
// Channels: tick_in carries one control tick per beat (pitch angle, pitch
// rate, both wheel speeds, speed command); tick_out returns one beat per
// tick with the saturated motor drive and the integral clamp flag. The
// configuration port writes a register whenever cfg_write is high; write
// it only while no tick is in flight.
// Timing: a tick is worked on alone. Its result is loaded into the output
// register at the end of its work, and the next tick can be taken in the
// cycle after the result is loaded. The work is two passes through the
// pair of two-bit digit-serial multipliers (the digit steps and a check
// that they finished; the integral and proportional speed gains first,
// then the tilt and rate gains), with the integral add, clamping, target
// and pitch error between them, then the drive add, saturation with the
// result load, and the return to idle.
// The result sits in an output register, so the next tick is taken while
// it waits; if the receiver is still stalled when that tick finishes, it
// waits in the last step and tick_in stays not ready.
// Reset (synchronous, active high) restores the register defaults, clears
// the speed integral and drops any tick in flight or result not taken.
// Depends on cbc_pkg, cbc_in_if, cbc_out_if, cbc_cfg and cbc_mul.
module cascaded_balance_controller_core (
  input  logic                             clk,
  input  logic                             rst,
  cbc_in_if.sink                           tick_in,
  cbc_out_if.source                        tick_out,
  input  logic                             cfg_write,
  input  logic [cbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cbc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL_A = 4'd1;
  localparam logic [3:0] ST_SUM   = 4'd2;
  localparam logic [3:0] ST_CLAMP = 4'd3;
  localparam logic [3:0] ST_TGT   = 4'd4;
  localparam logic [3:0] ST_PERR  = 4'd5;
  localparam logic [3:0] ST_MUL_B = 4'd6;
  localparam logic [3:0] ST_DRIVE = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  cfg_t cfg;

  logic [3:0] state;
  logic [3:0] state_next;

  logic                      accept;
  logic                      mul_start;
  logic                      load_out;
  logic signed [ERR_W-1:0]   err9;
  logic signed [SUM_W:0]     perr;
  logic signed [MUL_M_W-1:0] m0_operand;
  logic signed [MUL_M_W-1:0] m1_operand;
  logic [GAIN_W-1:0]         m0_gain;
  logic [GAIN_W-1:0]         m1_gain;
  logic                      m0_busy;
  logic                      m1_busy;
  logic signed [MUL_P_W-1:0] p0;
  logic signed [MUL_P_W-1:0] p1;
  logic signed [SUM_W-1:0]   lim_pos;
  logic signed [SUM_W-1:0]   lim_neg;
  logic                      sat_hi;
  logic                      sat_lo;

  logic signed [PDIFF_W-1:0]  pdiff;
  logic signed [FIELD_W-1:0]  rate;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    target;
  logic signed [INTEG_W-1:0]  integral;
  logic                       clamp_flag;
  logic signed [ACCUM_W-1:0]  drive_sum;
  logic                       out_valid;
  logic signed [DRIVE_W-1:0]  motor_drive;
  logic                       integral_clamped;

  cbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign tick_in.ready = (state == ST_IDLE);
  assign accept        = tick_in.valid && tick_in.ready;
  assign mul_start     = accept || (state == ST_PERR);
  assign load_out      = (state == ST_OUT) && (!out_valid || tick_out.ready);

  // Speed error kept exactly in Q.9: twice the command minus both wheels.
  always_comb begin
    err9 = (ERR_W'(tick_in.speed_command) <<< 1)
         - (ERR_W'(tick_in.wheel_speed_right) + ERR_W'(tick_in.wheel_speed_left));
    perr = (SUM_W + 1)'($signed({pdiff, 16'h0000})) - (SUM_W + 1)'(target);
  end

  // First pass multiplies the speed error by both speed gains; the second
  // pass takes the pitch error and the pitch rate.
  always_comb begin
    if (state == ST_PERR) begin
      m0_operand = MUL_M_W'(perr);
      m0_gain    = cfg.tilt_gain;
      m1_operand = MUL_M_W'(rate);
      m1_gain    = cfg.rate_gain;
    end else begin
      m0_operand = MUL_M_W'(err9);
      m0_gain    = cfg.speed_int_gain;
      m1_operand = MUL_M_W'(err9);
      m1_gain    = cfg.speed_prop_gain;
    end
  end

  cbc_mul u_mul0 (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (m0_operand),
    .gain         (m0_gain),
    .busy         (m0_busy),
    .product      (p0)
  );

  cbc_mul u_mul1 (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (m1_operand),
    .gain         (m1_gain),
    .busy         (m1_busy),
    .product      (p1)
  );

  always_comb begin
    lim_pos = SUM_W'({1'b0, cfg.integral_limit});
    lim_neg = -lim_pos;
    sat_hi  = !drive_sum[ACCUM_W-1] && (|drive_sum[ACCUM_W-2:DRIVE_W-1]);
    sat_lo  = drive_sum[ACCUM_W-1] && !(&drive_sum[ACCUM_W-2:DRIVE_W-1]);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_MUL_A;
      ST_MUL_A: if (!m0_busy) state_next = ST_SUM;
      ST_SUM:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_TGT;
      ST_TGT:   state_next = ST_PERR;
      ST_PERR:  state_next = ST_MUL_B;
      ST_MUL_B: if (!m0_busy) state_next = ST_DRIVE;
      ST_DRIVE: state_next = ST_OUT;
      ST_OUT:   if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      integral  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLAMP) begin
        if (sum > lim_pos) begin
          integral <= INTEG_W'(lim_pos);
        end else if (sum < lim_neg) begin
          integral <= INTEG_W'(lim_neg);
        end else begin
          integral <= INTEG_W'(sum);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (tick_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The speed-gain products are Q.25; dropping the low bit is a floor to Q.24.
  always_ff @(posedge clk) begin
    if (accept) begin
      pdiff <= PDIFF_W'(tick_in.pitch_angle) - PDIFF_W'(cfg.pitch_offset);
      rate  <= tick_in.pitch_rate;
    end
    if (state == ST_SUM) begin
      sum <= SUM_W'(integral) + SUM_W'($signed(p0[SUM_W-1:1]));
    end
    if (state == ST_CLAMP) begin
      clamp_flag <= (sum > lim_pos) || (sum < lim_neg);
    end
    if (state == ST_TGT) begin
      target <= SUM_W'($signed(p1[SUM_W-1:1])) + SUM_W'(integral);
    end
    if (state == ST_DRIVE) begin
      drive_sum <= ACCUM_W'($signed(p0[MUL_P_W-1:16])) + ACCUM_W'($signed(p1[39:0]));
    end
    if (load_out) begin
      integral_clamped <= clamp_flag;
      if (sat_hi) begin
        motor_drive <= {1'b0, {(DRIVE_W-1){1'b1}}};
      end else if (sat_lo) begin
        motor_drive <= {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
        motor_drive <= drive_sum[DRIVE_W-1:0];
      end
    end
  end

  assign tick_out.valid            = out_valid;
  assign tick_out.motor_drive      = motor_drive;
  assign tick_out.integral_clamped = integral_clamped;

  // Both multipliers are started together and must run in lock step.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    m0_busy == m1_busy)
    else $error("multiplier lanes out of step");

  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    accept |-> !m0_busy && !m1_busy)
    else $error("tick accepted while a multiplier is busy");

  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TGT) |->
      (SUM_W'(integral) <= lim_pos) && (SUM_W'(integral) >= lim_neg))
    else $error("speed integral outside its limit");

  a_clamp_at_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TGT) && clamp_flag |->
      (SUM_W'(integral) == lim_pos) || (SUM_W'(integral) == lim_neg))
    else $error("clamp flag set but integral not at a bound");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && (state == ST_IDLE))
    else $error("result load did not present a beat");

endmodule

// ===== rtl/cbc_cfg.sv =====
// Configuration register file of the balance controller.
// Decodes the write port into the register bundle; depends on cbc_pkg.
module cbc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cbc_pkg::cfg_t                    cfg
);
  import cbc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tilt_gain       <= RST_TILT_GAIN;
      cfg.rate_gain       <= RST_RATE_GAIN;
      cfg.speed_prop_gain <= RST_SPEED_PROP_GAIN;
      cfg.speed_int_gain  <= RST_SPEED_INT_GAIN;
      cfg.pitch_offset    <= RST_PITCH_OFFSET;
      cfg.integral_limit  <= RST_INTEGRAL_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TILT_GAIN:       cfg.tilt_gain       <= cfg_data[GAIN_W-1:0];
        REG_RATE_GAIN:       cfg.rate_gain       <= cfg_data[GAIN_W-1:0];
        REG_SPEED_PROP_GAIN: cfg.speed_prop_gain <= cfg_data[GAIN_W-1:0];
        REG_SPEED_INT_GAIN:  cfg.speed_int_gain  <= cfg_data[GAIN_W-1:0];
        REG_PITCH_OFFSET:    cfg.pitch_offset    <= $signed(cfg_data[FIELD_W-1:0]);
        REG_INTEGRAL_LIMIT:  cfg.integral_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cbc_mul.sv =====
// Digit-serial multiplier: signed multiplicand times unsigned gain.
// The gain shifts out two bits per cycle while product bits shift in behind
// it, so the adder is only as wide as the multiplicand. Depends on cbc_pkg.
module cbc_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [cbc_pkg::MUL_M_W-1:0]   multiplicand,
  input  logic [cbc_pkg::GAIN_W-1:0]           gain,
  output logic                                 busy,
  output logic signed [cbc_pkg::MUL_P_W-1:0]   product
);
  import cbc_pkg::*;

  logic signed [MUL_M_W-1:0]   mcand;
  logic signed [MUL_ACC_W-1:0] acc;
  logic [GAIN_W-1:0]           q;
  logic [MUL_CNT_W-1:0]        cnt;
  logic signed [MUL_SUM_W-1:0] part_lo;
  logic signed [MUL_SUM_W-1:0] part_hi;
  logic signed [MUL_SUM_W-1:0] step_sum;

  // The running high part never exceeds the multiplicand in magnitude, so
  // adding up to three times it and dropping two bits cannot overflow.
  always_comb begin
    part_lo  = q[0] ? MUL_SUM_W'(mcand) : '0;
    part_hi  = q[1] ? (MUL_SUM_W'(mcand) <<< 1) : '0;
    step_sum = MUL_SUM_W'(acc) + part_lo + part_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= multiplicand;
      acc   <= '0;
      q     <= gain;
    end else if (busy) begin
      acc <= step_sum[MUL_SUM_W-1:MUL_DIGIT_W];
      q   <= {step_sum[MUL_DIGIT_W-1:0], q[GAIN_W-1:MUL_DIGIT_W]};
    end
  end

  assign product = {acc[MUL_ACC_W-2:0], q};

endmodule

// ===== sim/cascaded_balance_controller_core_test.sv =====
`timescale 1ns / 1ps
// Testbench for cascaded_balance_controller_core: a scoreboard class predicts each drive beat
// and checks the block's output beats in order. Depends on the core, cbc_pkg, cbc_in_if and cbc_out_if.
package cbc_tb_pkg;
  import cbc_pkg::*;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } drive_beat_t;

  class balance_scoreboard;
    logic [GAIN_W-1:0]         k_tilt;
    logic [GAIN_W-1:0]         k_rate;
    logic [GAIN_W-1:0]         k_speed_p;
    logic [GAIN_W-1:0]         k_speed_i;
    logic signed [FIELD_W-1:0] upright_offset;
    logic [LIMIT_W-1:0]        integ_bound;
    logic signed [INTEG_W-1:0] integ_acc;
    drive_beat_t               expected_drives[$];
    int                        ticks_noted;
    int                        results_seen;
    int                        failures;
    int                        clamp_count;
    int                        saturate_count;

    function new();
      k_tilt         = RST_TILT_GAIN;
      k_rate         = RST_RATE_GAIN;
      k_speed_p      = RST_SPEED_PROP_GAIN;
      k_speed_i      = RST_SPEED_INT_GAIN;
      upright_offset = RST_PITCH_OFFSET;
      integ_bound    = RST_INTEGRAL_LIMIT;
      integ_acc      = '0;
      ticks_noted    = 0;
      results_seen   = 0;
      failures       = 0;
      clamp_count    = 0;
      saturate_count = 0;
    endfunction

    // Bits above a register's width are dropped; unknown indexes do nothing.
    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_TILT_GAIN:       k_tilt = data[GAIN_W-1:0];
        REG_RATE_GAIN:       k_rate = data[GAIN_W-1:0];
        REG_SPEED_PROP_GAIN: k_speed_p = data[GAIN_W-1:0];
        REG_SPEED_INT_GAIN:  k_speed_i = data[GAIN_W-1:0];
        REG_PITCH_OFFSET:    upright_offset = data[FIELD_W-1:0];
        REG_INTEGRAL_LIMIT:  integ_bound = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic signed [FIELD_W-1:0] pitch, rate, right_spd, left_spd, cmd);
      longint      spd_err;
      longint      integ_sum;
      longint      bound;
      longint      tgt_pitch;
      longint      tilt_err;
      longint      coarse;
      longint      frac;
      longint      tilt_part;
      longint      drv;
      drive_beat_t beat;
      // Speed error in Q.9 keeps the half bit of the wheel average.
      spd_err = 2 * longint'(cmd) - (longint'(right_spd) + longint'(left_spd));
      integ_sum = longint'(integ_acc) + ((spd_err * longint'(k_speed_i)) >>> 1);
      bound = longint'(integ_bound);
      beat.clamped = 1'b0;
      if (integ_sum > bound) begin
        integ_sum = bound;
        beat.clamped = 1'b1;
      end else if (integ_sum < -bound) begin
        integ_sum = -bound;
        beat.clamped = 1'b1;
      end
      integ_acc = integ_sum[INTEG_W-1:0];
      tgt_pitch = ((spd_err * longint'(k_speed_p)) >>> 1) + integ_sum;
      tilt_err = (longint'(pitch) - longint'(upright_offset)) * 65536 - tgt_pitch;
      // The full product would overflow 64 bits, so the floor division by 2^16 is split
      // into the whole part and the nonnegative remainder.
      coarse = tilt_err >>> 16;
      frac = tilt_err - (coarse <<< 16);
      tilt_part = longint'(k_tilt) * coarse + ((longint'(k_tilt) * frac) >>> 16);
      drv = tilt_part + longint'(k_rate) * longint'(rate);
      if (drv > 64'sd2147483647) begin
        drv = 64'sd2147483647;
        saturate_count++;
      end else if (drv < -64'sd2147483648) begin
        drv = -64'sd2147483648;
        saturate_count++;
      end
      beat.drive = drv[DRIVE_W-1:0];
      if (beat.clamped) clamp_count++;
      ticks_noted++;
      expected_drives.push_back(beat);
    endfunction

    function void complain(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void check_result(logic signed [DRIVE_W-1:0] drive, logic clamped);
      drive_beat_t want;
      results_seen++;
      if (expected_drives.size() == 0) begin
        complain($sformatf("beat %0d arrived with no tick outstanding: drive %0d clamp %0b",
                           results_seen, drive, clamped));
        return;
      end
      want = expected_drives.pop_front();
      if (drive !== want.drive || clamped !== want.clamped)
        complain($sformatf("beat %0d: drive %0d clamp %0b, expected drive %0d clamp %0b",
                           results_seen, drive, clamped, want.drive, want.clamped));
    endfunction

    function void flag_leftovers();
      drive_beat_t want;
      while (expected_drives.size() != 0) begin
        want = expected_drives.pop_front();
        complain($sformatf("no beat for expected drive %0d clamp %0b", want.drive, want.clamped));
      end
    endfunction
  endclass
endpackage

module cascaded_balance_controller_core_test;
  import cbc_pkg::*;
  import cbc_tb_pkg::*;

  // Indexes past the register map; writes there must leave every register alone.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     ticks_sent;
  int                     settings_used;
  balance_scoreboard      sb;

  cbc_in_if  tick_in();
  cbc_out_if tick_out();

  cascaded_balance_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .tick_in   (tick_in),
    .tick_out  (tick_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    tick_out.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && tick_in.valid && tick_in.ready)
      sb.note_tick(tick_in.pitch_angle, tick_in.pitch_rate, tick_in.wheel_speed_right,
                   tick_in.wheel_speed_left, tick_in.speed_command);
    if (!rst && tick_out.valid && tick_out.ready)
      sb.check_result(tick_out.motor_drive, tick_out.integral_clamped);
  end

  task automatic send_tick(logic [FIELD_W-1:0] pitch, rate, right_spd, left_spd, cmd);
    if ($urandom_range(99) < send_idle_pct) begin
      tick_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    tick_in.valid             <= 1'b1;
    tick_in.pitch_angle       <= pitch;
    tick_in.pitch_rate        <= rate;
    tick_in.wheel_speed_right <= right_spd;
    tick_in.wheel_speed_left  <= left_spd;
    tick_in.speed_command     <= cmd;
    @(posedge clk);
    while (!tick_in.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Holds the sender off until every tick has produced its beat.
  task automatic wait_drained();
    tick_in.valid <= 1'b0;
    while (sb.results_seen < ticks_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    sb.write_reg(index, data);
    @(posedge clk);
  endtask

  task automatic close_writes();
    cfg_write <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] field_value();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] gain_value();
    case ($urandom_range(4))
      0: return 31'($urandom);
      1: return 31'($urandom_range(4095));
      2: return 31'($urandom_range(262143));
      3: return 31'h00FF_FFFF;
      default: return 31'd0;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] limit_value();
    case ($urandom_range(3))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(32'h1000_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  // Style 0 puts every register at its top, style 1 at its bottom; others are random.
  task automatic program_setting(int style);
    wait_drained();
    if (style == 0) begin
      write_reg(REG_TILT_GAIN, 31'h00FF_FFFF);
      write_reg(REG_RATE_GAIN, 31'h00FF_FFFF);
      write_reg(REG_SPEED_PROP_GAIN, 31'h00FF_FFFF);
      write_reg(REG_SPEED_INT_GAIN, 31'h00FF_FFFF);
      write_reg(REG_PITCH_OFFSET, 31'h0000_7FFF);
      write_reg(REG_INTEGRAL_LIMIT, 31'h7FFF_FFFF);
    end else if (style == 1) begin
      write_reg(REG_TILT_GAIN, 31'd0);
      write_reg(REG_RATE_GAIN, 31'd0);
      write_reg(REG_SPEED_PROP_GAIN, 31'd0);
      write_reg(REG_SPEED_INT_GAIN, 31'd0);
      write_reg(REG_PITCH_OFFSET, 31'h0000_8000);
      write_reg(REG_INTEGRAL_LIMIT, 31'd0);
    end else begin
      write_reg(REG_TILT_GAIN, gain_value());
      write_reg(REG_RATE_GAIN, gain_value());
      write_reg(REG_SPEED_PROP_GAIN, gain_value());
      write_reg(REG_SPEED_INT_GAIN, gain_value());
      write_reg(REG_PITCH_OFFSET,
                ($urandom_range(1) == 0) ? 31'($urandom) : 31'($urandom_range(1023)));
      write_reg(REG_INTEGRAL_LIMIT, limit_value());
      if ($urandom_range(1) == 0) write_reg(REG_SPARE_HI, 31'($urandom));
    end
    close_writes();
  endtask

  // Most ticks keep both wheels near the command so the integral stays off its bounds.
  task automatic random_tick();
    logic [FIELD_W-1:0] cmd;
    logic [FIELD_W-1:0] right_spd;
    logic [FIELD_W-1:0] left_spd;
    cmd = field_value();
    if ($urandom_range(9) < 6) begin
      right_spd = cmd + 16'($urandom_range(64)) - 16'd32;
      left_spd  = cmd + 16'($urandom_range(64)) - 16'd32;
    end else begin
      right_spd = field_value();
      left_spd  = field_value();
    end
    send_tick(field_value(), field_value(), right_spd, left_spd, cmd);
  endtask

  task automatic run_directed();
    // Register defaults: field extremes and alternating bit patterns.
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_tick(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_tick(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    // Full integral gain (upper data bits set and dropped) drives the integral into both bounds.
    wait_drained();
    write_reg(REG_SPEED_INT_GAIN, 31'h7FFF_FFFF);
    write_reg(REG_INTEGRAL_LIMIT, 31'h0100_0000);
    close_writes();
    send_tick(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF);
    send_tick(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF);
    send_tick(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_tick(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF);
    // A limit lowered under the stored integral clamps on the next tick with no error.
    wait_drained();
    write_reg(REG_INTEGRAL_LIMIT, 31'd1000);
    close_writes();
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // Zero limit: clamps whenever the sum is non-zero.
    wait_drained();
    write_reg(REG_INTEGRAL_LIMIT, 31'd0);
    close_writes();
    send_tick(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100);
    send_tick(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    // Writes past the map are ignored; the offset keeps only its low 16 bits.
    wait_drained();
    write_reg(REG_SPARE_LO, 31'($urandom));
    write_reg(REG_SPARE_HI, 31'($urandom));
    write_reg(REG_PITCH_OFFSET, 31'h7FFF_8000);
    write_reg(REG_TILT_GAIN, 31'h7FFF_FFFF);
    close_writes();
    send_tick(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();
    write_reg(REG_PITCH_OFFSET, 31'h0000_7FFF);
    close_writes();
    send_tick(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();
    write_reg(REG_TILT_GAIN, 31'd0);
    write_reg(REG_RATE_GAIN, 31'h00FF_FFFF);
    close_writes();
    send_tick(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  initial begin
    sb = new();
    ticks_sent = 0;
    settings_used = 0;
    send_idle_pct = 29;
    recv_idle_pct = 86;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    tick_in.valid <= 1'b0;
    tick_in.pitch_angle <= '0;
    tick_in.pitch_rate <= '0;
    tick_in.wheel_speed_right <= '0;
    tick_in.wheel_speed_left <= '0;
    tick_in.speed_command <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int blk = 0; blk < 5; blk++) begin
      if (blk < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 86;
      end else if (blk < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_setting(blk);
      repeat (100) random_tick();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    sb.flag_leftovers();
    $display("Ran %0d control ticks across %0d register settings and three idling patterns.",
             ticks_sent, settings_used);
    $display("The integral clamped on %0d ticks and the drive saturated on %0d; %0d failures.",
             sb.clamp_count, sb.saturate_count, sb.failures);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
